### rtl/otgr_pkg.sv
// Shared types, panel command codes and the 5x7 font table for the
// OLED text renderer. No dependencies.
package otgr_pkg;

  localparam int unsigned FONT_W = 5;

  localparam logic [7:0] CMD_COL_ADDR  = 8'h21;
  localparam logic [7:0] CMD_PAGE_ADDR = 8'h22;
  localparam logic [7:0] BLANK_COLUMN  = 8'h00;
  localparam logic [7:0] CHAR_NL       = 8'h0A;
  localparam logic [7:0] FIRST_GLYPH   = 8'h20;
  localparam logic [7:0] LAST_GLYPH    = 8'h7E;

  // Output byte sequence: window commands, then font columns, then spacer.
  localparam logic [3:0] STEP_COL_CMD  = 4'd0;
  localparam logic [3:0] STEP_COL_LO   = 4'd1;
  localparam logic [3:0] STEP_COL_HI   = 4'd2;
  localparam logic [3:0] STEP_PAGE_CMD = 4'd3;
  localparam logic [3:0] STEP_PAGE_LO  = 4'd4;
  localparam logic [3:0] STEP_PAGE_HI  = 4'd5;
  localparam logic [3:0] STEP_GLYPH    = 4'd6;
  localparam logic [3:0] STEP_SPACER   = 4'd11;

  typedef struct packed {
    logic       win;
    logic       glyph;
    logic [2:0] page;
    logic [6:0] column;
    logic [7:0] char_code;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Column 0 of each glyph sits in the top byte.
  localparam logic [39:0] FONT_ROM [0:94] = '{
    40'h0000000000, 40'h00002f0000, 40'h0007000700, 40'h147f147f14, 40'h242a7f2a12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001c224100, 40'h0041221c00,
    40'h14083e0814, 40'h08083e0808, 40'h0000a06000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
    40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503, 40'h3649494936,
    40'h064949291e, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324959513e, 40'h7c1211127c, 40'h7f49494936,
    40'h3e41414122, 40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
    40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
    40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e, 40'h7f09090906, 40'h3e4151215e,
    40'h7f09192946, 40'h4649494931, 40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f,
    40'h3f4038403f, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
    40'h55aa55aa55, 40'h0041417f00, 40'h0402010204, 40'h4040404040, 40'h0003050000,
    40'h2054545478, 40'h7f48444438, 40'h3844444420, 40'h384444487f, 40'h3854545418,
    40'h087e090102, 40'h18a4a4a47c, 40'h7f08040478, 40'h00447d4000, 40'h4080847d00,
    40'h7f10284400, 40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
    40'hfc24242418, 40'h18242418fc, 40'h7c08040408, 40'h4854545420, 40'h043f444020,
    40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c, 40'h4428102844, 40'h1ca0a0a07c,
    40'h4464544c44, 40'h00107c8200, 40'h0000ff0000, 40'h00827c1000, 40'h0006090906
  };

  // Font column idx of a character; codes outside the glyph range are blank.
  function automatic logic [7:0] glyph_column(input logic [7:0] code,
                                              input logic [2:0] idx);
    logic [6:0]  slot;
    logic [39:0] bits;
    logic [7:0]  res;
    slot = 7'(code - FIRST_GLYPH);
    res  = BLANK_COLUMN;
    if (code >= FIRST_GLYPH && code <= LAST_GLYPH) begin
      bits = FONT_ROM[slot];
      case (idx)
        3'd0:    res = bits[39:32];
        3'd1:    res = bits[31:24];
        3'd2:    res = bits[23:16];
        3'd3:    res = bits[15:8];
        3'd4:    res = bits[7:0];
        default: res = BLANK_COLUMN;
      endcase
    end
    return res;
  endfunction

endpackage

### rtl/otgr_if.sv
// Valid/ready channel interfaces for the OLED text renderer: requests in,
// panel bytes out. No dependencies.
interface otgr_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] char_code;
  logic [7:0] target_page;
  logic [7:0] target_column;

  modport source (output valid, req_type, char_code, target_page, target_column,
                  input ready);
  modport sink (input valid, req_type, char_code, target_page, target_column,
                output ready);
endinterface

interface otgr_res_if;
  logic       valid;
  logic       ready;
  logic       is_command;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, is_command, out_byte, last, input ready);
  modport sink (input valid, is_command, out_byte, last, output ready);
endinterface

### rtl/oled_text_glyph_renderer.sv
// Top level of the OLED text renderer: front end, job queue and byte
// sequencer. Depends on otgr_pkg, otgr_if, otgr_front, otgr_queue, otgr_back.

// Turns character and set-cursor requests into the command/data byte stream
// of a page-addressed monochrome OLED with a 5x7 font. A valid set-cursor
// request gives 6 bytes, a newline 6, a character 6 or 12 (when it wraps);
// an invalid set-cursor request gives none. Bytes leave one per cycle from
// an output register while the sink is ready. A two-entry job queue sits
// behind the front end, so up to two further requests are taken while bytes
// are still going out; a job passes through the queue and the sequencer's
// job register before its first byte reaches the output register.
module oled_text_glyph_renderer #(
  parameter int unsigned PANEL_COLUMNS = 128,
  parameter int unsigned LAST_PAGE     = 7
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  otgr_req_if.sink   req_i,
  otgr_res_if.source res_o
);
  import otgr_pkg::*;

  job_t      push_job, pop_job;
  logic      push, pop;
  q_status_t q_status;

  otgr_front #(
    .PANEL_COLUMNS(PANEL_COLUMNS),
    .LAST_PAGE    (LAST_PAGE)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .q_status_i(q_status),
    .push_o    (push),
    .push_job_o(push_job)
  );

  otgr_queue #(
    .DEPTH(2)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_job_i(push_job),
    .pop_i     (pop),
    .pop_job_o (pop_job),
    .status_o  (q_status)
  );

  otgr_back #(
    .PANEL_COLUMNS(PANEL_COLUMNS),
    .LAST_PAGE    (LAST_PAGE)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_i     (pop_job),
    .q_status_i(q_status),
    .pop_o     (pop),
    .res_o     (res_o)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full)
    else $error("job pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("job popped from empty queue");

  a_spacer_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.is_command && res_o.last) |-> (res_o.out_byte == BLANK_COLUMN))
    else $error("glyph spacer byte not blank");

  a_empty_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_status.full && pop && !push) |=> !q_status.full)
    else $error("queue count not reduced by pop");

endmodule

### rtl/otgr_queue.sv
// Short job queue between the request front end and the byte sequencer.
// Depends on otgr_pkg.
module otgr_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  otgr_pkg::job_t     push_job_i,
  input  logic               pop_i,
  output otgr_pkg::job_t     pop_job_o,
  output otgr_pkg::q_status_t status_o
);
  import otgr_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign status_o.full  = (count_q == CntW'(DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_job_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

### rtl/otgr_front.sv
// Request front end: holds the text cursor, applies set-cursor and wrap
// rules, and queues one job per request that yields bytes. Depends on otgr_pkg.
module otgr_front #(
  parameter int unsigned PANEL_COLUMNS = 128,
  parameter int unsigned LAST_PAGE     = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  otgr_req_if.sink            req_i,
  input  otgr_pkg::q_status_t q_status_i,
  output logic                push_o,
  output otgr_pkg::job_t      push_job_o
);
  import otgr_pkg::*;

  logic [2:0] page_q, page_d;
  logic [6:0] col_q, col_d;
  logic       accept, is_set, tgt_ok, is_nl, wrap;
  logic [2:0] page_wrap;
  logic [6:0] col_base;
  logic [7:0] col_sum;

  assign req_i.ready = !q_status_i.full;
  assign accept      = req_i.valid && req_i.ready;
  assign is_set      = req_i.req_type;
  assign tgt_ok      = (req_i.target_page <= 8'(LAST_PAGE)) &&
                       (req_i.target_column < 8'(PANEL_COLUMNS));
  assign is_nl       = (req_i.char_code == CHAR_NL);
  assign wrap        = is_nl || (({1'b0, col_q} + 8'(FONT_W)) >= 8'(PANEL_COLUMNS));
  assign page_wrap   = (page_q >= 3'(LAST_PAGE)) ? 3'd0 : page_q + 3'd1;
  assign col_base    = wrap ? 7'd0 : col_q;
  assign col_sum     = {1'b0, col_base} + 8'(FONT_W + 1);

  always_comb begin
    page_d                = page_q;
    col_d                 = col_q;
    push_o                = 1'b0;
    push_job_o.char_code  = req_i.char_code;
    if (is_set) begin
      push_job_o.win    = 1'b1;
      push_job_o.glyph  = 1'b0;
      push_job_o.page   = req_i.target_page[2:0];
      push_job_o.column = req_i.target_column[6:0];
      if (accept && tgt_ok) begin
        push_o = 1'b1;
        page_d = req_i.target_page[2:0];
        col_d  = req_i.target_column[6:0];
      end
    end else begin
      push_job_o.win    = wrap;
      push_job_o.glyph  = !is_nl;
      push_job_o.page   = wrap ? page_wrap : page_q;
      push_job_o.column = col_base;
      if (accept) begin
        push_o = 1'b1;
        page_d = wrap ? page_wrap : page_q;
        if (is_nl) begin
          col_d = 7'd0;
        end else begin
          col_d = col_sum[7] ? 7'h7F : col_sum[6:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q <= '0;
      col_q  <= '0;
    end else begin
      page_q <= page_d;
      col_q  <= col_d;
    end
  end

endmodule

### rtl/otgr_back.sv
// Byte sequencer: takes queued jobs and emits window commands and font columns through
// an output register, one byte per cycle while the sink is ready. Depends on otgr_pkg.
module otgr_back #(
  parameter int unsigned PANEL_COLUMNS = 128,
  parameter int unsigned LAST_PAGE     = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  otgr_pkg::job_t      job_i,
  input  otgr_pkg::q_status_t q_status_i,
  output logic                pop_o,
  otgr_res_if.source          res_o
);
  import otgr_pkg::*;

  job_t       job_q, job_d;
  logic       active_q, active_d;
  logic [3:0] step_q, step_d;
  logic       vld_q, vld_d, cmd_q, cmd_d, last_q, last_d;
  logic [7:0] byte_q, byte_d;
  logic       adv, last_step;
  logic [7:0] cur_byte;
  logic [3:0] glyph_off;

  assign adv       = !vld_q || res_o.ready;
  assign last_step = (step_q == STEP_SPACER) || (step_q == STEP_PAGE_HI && !job_q.glyph);
  assign glyph_off = step_q - STEP_GLYPH;

  always_comb begin
    case (step_q)
      STEP_COL_CMD:  cur_byte = CMD_COL_ADDR;
      STEP_COL_LO:   cur_byte = {1'b0, job_q.column};
      STEP_COL_HI:   cur_byte = 8'(PANEL_COLUMNS - 1);
      STEP_PAGE_CMD: cur_byte = CMD_PAGE_ADDR;
      STEP_PAGE_LO:  cur_byte = {5'd0, job_q.page};
      STEP_PAGE_HI:  cur_byte = 8'(LAST_PAGE);
      STEP_SPACER:   cur_byte = BLANK_COLUMN;
      default:       cur_byte = glyph_column(job_q.char_code, glyph_off[2:0]);
    endcase
  end

  always_comb begin
    job_d    = job_q;
    active_d = active_q;
    step_d   = step_q;
    vld_d    = vld_q;
    cmd_d    = cmd_q;
    last_d   = last_q;
    byte_d   = byte_q;
    pop_o    = 1'b0;
    if (adv) begin
      vld_d = active_q;
      if (active_q) begin
        cmd_d  = (step_q < STEP_GLYPH);
        byte_d = cur_byte;
        last_d = last_step;
        if (last_step) begin
          active_d = 1'b0;
        end else begin
          step_d = step_q + 4'd1;
        end
      end
    end
    if ((!active_q || (adv && last_step)) && !q_status_i.empty) begin
      pop_o    = 1'b1;
      job_d    = job_i;
      active_d = 1'b1;
      step_d   = job_i.win ? STEP_COL_CMD : STEP_GLYPH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      vld_q    <= 1'b0;
      step_q   <= STEP_COL_CMD;
    end else begin
      active_q <= active_d;
      vld_q    <= vld_d;
      step_q   <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    cmd_q  <= cmd_d;
    last_q <= last_d;
    byte_q <= byte_d;
  end

  assign res_o.valid      = vld_q;
  assign res_o.is_command = cmd_q;
  assign res_o.out_byte   = byte_q;
  assign res_o.last       = last_q;

endmodule
